// ===== design/hsr_pkg.sv =====
// Shared constants and types for the heap sort record block.
`default_nettype none
package hsr_pkg;
  localparam int MaxRecords  = 64;
  localparam int KeyBits     = 16;
  localparam int PayloadBits = 32;
  localparam int RecordBits  = KeyBits + PayloadBits;
  localparam int AddrBits    = $clog2(MaxRecords);
  localparam int CountBits   = $clog2(MaxRecords + 1);

  typedef logic [AddrBits-1:0]    addr_t;
  typedef logic [CountBits-1:0]   count_t;
  typedef logic [KeyBits-1:0]     key_t;
  typedef logic [PayloadBits-1:0] payload_t;
  typedef logic [RecordBits-1:0]  record_t;

  localparam addr_t  AddrOne  = addr_t'(1);
  localparam count_t CountOne = count_t'(1);
  localparam count_t CountMax = count_t'(MaxRecords);

  typedef enum logic [2:0] {
    OP_NONE,
    OP_WRITE_IN,
    OP_READ,
    OP_WRITE
  } mem_op_t;

  typedef struct packed {
    mem_op_t op;
    addr_t   addr;
    logic    data_sel;
    logic    load_a;
    logic    load_b;
  } dp_cmd_t;

  typedef struct packed {
    logic c_gt_big;
  } dp_status_t;
endpackage
`default_nettype wire

// ===== design/heap_sort_records_top.sv =====
// Top level of the heap sort record block.
// channel | handshake    | fields
// input   | start, busy  | item_key, item_payload, last_item
// result  | strobe       | out_key, out_payload, out_last, overflowed
// Load one record per cycle while busy is low; busy rises after the transaction marked last.
// Heap build runs N/2 sifts; extraction runs N sifts, each after a root swap.
// A sift level reads the node and its children, compares keys and swaps, all on the single memory port.
// Results leave in ascending key order; busy falls in the cycle of the last strobe.
// rst is synchronous; the receiver cannot stall results.
`default_nettype none
module heap_sort_records_top (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                start,
  output logic                               busy,
  input  wire logic [hsr_pkg::KeyBits-1:0]   item_key,
  input  wire logic [hsr_pkg::PayloadBits-1:0] item_payload,
  input  wire                                last_item,
  output logic                               strobe,
  output logic [hsr_pkg::KeyBits-1:0]        out_key,
  output logic [hsr_pkg::PayloadBits-1:0]    out_payload,
  output logic                               out_last,
  output logic                               overflowed
);
  hsr_pkg::dp_cmd_t    cmd;
  hsr_pkg::dp_status_t status;
  logic [hsr_pkg::KeyBits-1:0]     rd_key;
  logic [hsr_pkg::PayloadBits-1:0] rd_payload;

  hsr_datapath u_dp (
    .clk(clk), .item_key(item_key), .item_payload(item_payload),
    .cmd(cmd), .status(status), .rd_key(rd_key), .rd_payload(rd_payload)
  );

  hsr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .last_item(last_item),
    .status(status), .cmd(cmd), .busy(busy), .strobe(strobe),
    .out_last(out_last), .overflowed(overflowed)
  );

  always_ff @(posedge clk) begin
    out_key     <= rd_key;
    out_payload <= rd_payload;
  end
endmodule
`default_nettype wire

// ===== design/hsr_datapath.sv =====
// Datapath: record memory, working registers and key compare.
`default_nettype none
module hsr_datapath (
  input  wire                              clk,
  input  wire logic [hsr_pkg::KeyBits-1:0] item_key,
  input  wire logic [hsr_pkg::PayloadBits-1:0] item_payload,
  input  wire hsr_pkg::dp_cmd_t            cmd,
  output hsr_pkg::dp_status_t              status,
  output logic [hsr_pkg::KeyBits-1:0]      rd_key,
  output logic [hsr_pkg::PayloadBits-1:0]  rd_payload
);
  hsr_pkg::record_t mem [hsr_pkg::MaxRecords];
  hsr_pkg::record_t rd_data;
  hsr_pkg::record_t a_rec;
  hsr_pkg::record_t b_rec;
  hsr_pkg::record_t wr_data;

  assign wr_data = cmd.data_sel ? b_rec : a_rec;

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      hsr_pkg::OP_WRITE_IN: mem[cmd.addr] <= {item_key, item_payload};
      hsr_pkg::OP_WRITE:    mem[cmd.addr] <= wr_data;
      hsr_pkg::OP_READ:     rd_data <= mem[cmd.addr];
      default: ;
    endcase
    if (cmd.load_a) a_rec <= rd_data;
    if (cmd.load_b) b_rec <= rd_data;
  end

  assign status.c_gt_big = rd_data[hsr_pkg::RecordBits-1:hsr_pkg::PayloadBits] >
                           b_rec[hsr_pkg::RecordBits-1:hsr_pkg::PayloadBits];
  assign rd_key     = rd_data[hsr_pkg::RecordBits-1:hsr_pkg::PayloadBits];
  assign rd_payload = rd_data[hsr_pkg::PayloadBits-1:0];
endmodule
`default_nettype wire

// ===== design/hsr_ctrl.sv =====
// Controller: load, heap build, extraction and output sequencing.
`default_nettype none
module hsr_ctrl (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    start,
  input  wire                    last_item,
  input  wire hsr_pkg::dp_status_t status,
  output hsr_pkg::dp_cmd_t       cmd,
  output logic                   busy,
  output logic                   strobe,
  output logic                   out_last,
  output logic                   overflowed
);
  // a_rec: node being sifted, b_rec: larger of node and children so far
  typedef enum logic [3:0] {
    S_IDLE, S_NEXT, S_RD_CUR, S_LD_CUR, S_RD_L, S_CMP_L, S_RD_R, S_CMP_R,
    S_SWAP1, S_SWAP2, S_EXT_RD0, S_EXT_RDI, S_EXT_WL, S_EXT_WR, S_OUT_RD, S_OUT
  } state_t;

  state_t            state;
  hsr_pkg::count_t   count;
  hsr_pkg::count_t   count_next;
  hsr_pkg::count_t   hsize;
  hsr_pkg::count_t   bidx;
  hsr_pkg::count_t   ext;
  hsr_pkg::addr_t    cur;
  hsr_pkg::addr_t    big;
  hsr_pkg::addr_t    k;
  logic              drop;
  logic              building;
  logic              out_done;
  hsr_pkg::count_t   lc;
  hsr_pkg::count_t   rc;

  assign lc = {cur, 1'b1};
  assign rc = lc + hsr_pkg::CountOne;
  assign count_next = (count < hsr_pkg::CountMax) ? count + hsr_pkg::CountOne : count;
  assign out_done = (hsr_pkg::count_t'(k) + hsr_pkg::CountOne == count);

  always_comb begin
    cmd = '0;
    cmd.op = hsr_pkg::OP_NONE;
    unique case (state)
      S_IDLE: if (start && count < hsr_pkg::CountMax) begin
        cmd.op = hsr_pkg::OP_WRITE_IN;
        cmd.addr = count[hsr_pkg::AddrBits-1:0];
      end
      S_RD_CUR: begin
        cmd.op = hsr_pkg::OP_READ; cmd.addr = cur;
      end
      S_LD_CUR: begin cmd.load_a = 1'b1; cmd.load_b = 1'b1; end
      S_RD_L: begin
        cmd.op = hsr_pkg::OP_READ; cmd.addr = lc[hsr_pkg::AddrBits-1:0];
      end
      S_CMP_L: cmd.load_b = status.c_gt_big;
      S_RD_R: begin
        cmd.op = hsr_pkg::OP_READ; cmd.addr = rc[hsr_pkg::AddrBits-1:0];
      end
      S_CMP_R: cmd.load_b = status.c_gt_big;
      S_SWAP1: if (big != cur) begin
        cmd.op = hsr_pkg::OP_WRITE; cmd.addr = cur;
        cmd.data_sel = 1'b1;
      end
      S_SWAP2: begin
        cmd.op = hsr_pkg::OP_WRITE; cmd.addr = big;
      end
      S_EXT_RD0: begin
        cmd.op = hsr_pkg::OP_READ; cmd.addr = '0;
      end
      S_EXT_RDI: begin
        cmd.load_a = 1'b1;
        cmd.op = hsr_pkg::OP_READ; cmd.addr = hsr_pkg::addr_t'(ext - hsr_pkg::CountOne);
      end
      S_EXT_WL: begin
        cmd.load_b = 1'b1;
        cmd.op = hsr_pkg::OP_WRITE; cmd.addr = hsr_pkg::addr_t'(ext - hsr_pkg::CountOne);
      end
      S_EXT_WR: begin
        cmd.op = hsr_pkg::OP_WRITE; cmd.addr = '0;
        cmd.data_sel = 1'b1;
      end
      S_OUT_RD: begin
        cmd.op = hsr_pkg::OP_READ; cmd.addr = k;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; count <= '0; drop <= 1'b0; busy <= 1'b0; strobe <= 1'b0;
      out_last <= 1'b0; overflowed <= 1'b0;
    end else begin
      strobe <= (state == S_OUT);
      unique case (state)
        S_IDLE: if (start) begin
          count <= count_next;
          if (count == hsr_pkg::CountMax) drop <= 1'b1;
          if (last_item) begin
            busy <= 1'b1;
            hsize <= count_next;
            ext <= count_next;
            bidx <= count_next >> 1;
            building <= 1'b1;
            state <= S_NEXT;
          end
        end
        S_NEXT: if (building) begin
          if (bidx == '0) building <= 1'b0;
          else begin
            cur <= hsr_pkg::addr_t'(bidx - hsr_pkg::CountOne);
            bidx <= bidx - hsr_pkg::CountOne;
            state <= S_RD_CUR;
          end
        end else if (ext == '0) begin
          k <= '0; state <= S_OUT_RD;
        end else begin
          state <= S_EXT_RD0;
        end
        S_RD_CUR: state <= S_LD_CUR;
        S_LD_CUR: begin
          big <= cur;
          state <= (lc < hsize) ? S_RD_L : S_SWAP1;
        end
        S_RD_L: state <= S_CMP_L;
        S_CMP_L: begin
          if (status.c_gt_big) big <= lc[hsr_pkg::AddrBits-1:0];
          state <= (rc < hsize) ? S_RD_R : S_SWAP1;
        end
        S_RD_R: state <= S_CMP_R;
        S_CMP_R: begin
          if (status.c_gt_big) big <= rc[hsr_pkg::AddrBits-1:0];
          state <= S_SWAP1;
        end
        S_SWAP1: state <= (big == cur) ? S_NEXT : S_SWAP2;
        S_SWAP2: begin cur <= big; state <= S_RD_CUR; end
        S_EXT_RD0: state <= S_EXT_RDI;
        S_EXT_RDI: state <= S_EXT_WL;
        S_EXT_WL: state <= S_EXT_WR;
        S_EXT_WR: begin
          ext <= ext - hsr_pkg::CountOne;
          hsize <= ext - hsr_pkg::CountOne;
          cur <= '0;
          state <= S_RD_CUR;
        end
        S_OUT_RD: state <= S_OUT;
        S_OUT: begin
          out_last <= out_done;
          overflowed <= drop;
          if (out_done) begin
            busy <= 1'b0; count <= '0; drop <= 1'b0;
            state <= S_IDLE;
          end else begin
            k <= k + hsr_pkg::AddrOne;
            state <= S_OUT_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== dv/heap_sort_records_checker.sv =====
// Checker that predicts and compares the sorted record stream of the heap sort block.
`timescale 1ns / 100ps
module heap_sort_records_checker (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               start,
  input  wire                               busy,
  input  wire [hsr_pkg::KeyBits-1:0]        item_key,
  input  wire [hsr_pkg::PayloadBits-1:0]    item_payload,
  input  wire                               last_item,
  input  wire                               strobe,
  input  wire [hsr_pkg::KeyBits-1:0]        out_key,
  input  wire [hsr_pkg::PayloadBits-1:0]    out_payload,
  input  wire                               out_last,
  input  wire                               overflowed,
  output int                                fail_count,
  output int                                pending,
  output int                                records_sent,
  output int                                records_sorted
);
  typedef struct packed {
    hsr_pkg::key_t     key;
    hsr_pkg::payload_t payload;
    logic              last;
    logic              ovf;
  } sorted_rec_t;

  hsr_pkg::key_t     keys [hsr_pkg::MaxRecords];
  hsr_pkg::payload_t pays [hsr_pkg::MaxRecords];
  int                stored;
  logic              dropped;
  sorted_rec_t       sorted_q[$];

  function automatic void swap_entries(int a, int b);
    hsr_pkg::key_t     k;
    hsr_pkg::payload_t p;
    k = keys[a]; p = pays[a];
    keys[a] = keys[b]; pays[a] = pays[b];
    keys[b] = k; pays[b] = p;
  endfunction

  function automatic void sift(int size, int root);
    int cur, big;
    cur = root;
    forever begin
      big = cur;
      if (2 * cur + 1 < size && keys[2 * cur + 1] > keys[big]) big = 2 * cur + 1;
      if (2 * cur + 2 < size && keys[2 * cur + 2] > keys[big]) big = 2 * cur + 2;
      if (big == cur) return;
      swap_entries(cur, big);
      cur = big;
    end
  endfunction

  function automatic void sort_and_queue();
    sorted_rec_t r;
    for (int i = stored / 2; i > 0; i--) sift(stored, i - 1);
    for (int i = stored; i > 0; i--) begin
      swap_entries(0, i - 1);
      sift(i - 1, 0);
    end
    for (int k = 0; k < stored; k++) begin
      r.key = keys[k];
      r.payload = pays[k];
      r.last = (k + 1 == stored);
      r.ovf = dropped;
      sorted_q.push_back(r);
    end
    stored = 0;
    dropped = 1'b0;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      stored = 0;
      dropped = 1'b0;
      fail_count <= 0;
      records_sent <= 0;
      records_sorted <= 0;
      sorted_q.delete();
    end else begin
      if (strobe) begin
        records_sorted <= records_sorted + 1;
        if (sorted_q.size() == 0) begin
          $error("unexpected result: key %0h payload %0h", out_key, out_payload);
          fail_count <= fail_count + 1;
        end else begin
          sorted_rec_t e;
          e = sorted_q.pop_front();
          if (out_key !== e.key || out_payload !== e.payload || out_last !== e.last ||
              overflowed !== e.ovf) begin
            fail_count <= fail_count + 1;
            if (out_key !== e.key) $error("out_key exp %0h got %0h", e.key, out_key);
            if (out_payload !== e.payload)
              $error("out_payload exp %0h got %0h", e.payload, out_payload);
            if (out_last !== e.last) $error("out_last exp %0b got %0b", e.last, out_last);
            if (overflowed !== e.ovf) $error("overflowed exp %0b got %0b", e.ovf, overflowed);
          end
        end
      end
      if (start && !busy) begin
        records_sent <= records_sent + 1;
        if (stored < hsr_pkg::MaxRecords) begin
          keys[stored] = item_key;
          pays[stored] = item_payload;
          stored = stored + 1;
        end else begin
          dropped = 1'b1;
        end
        if (last_item) sort_and_queue();
      end
    end
  end

  assign pending = sorted_q.size();
endmodule

// ===== dv/heap_sort_records_top_tb.sv =====
// Testbench top: drives record sets into the heap sort block and reports the verdict.
`timescale 1ns / 100ps
module heap_sort_records_top_tb;
  localparam int WatchdogLimit = 200000;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  hsr_pkg::key_t     item_key;
  hsr_pkg::payload_t item_payload;
  logic              last_item;
  logic              strobe;
  hsr_pkg::key_t     out_key;
  hsr_pkg::payload_t out_payload;
  logic              out_last;
  logic              overflowed;
  int                fail_count;
  int                pending;
  int                records_sent;
  int                records_sorted;
  int                idle_pct;
  int                quiet_cycles;
  int                set_count;

  heap_sort_records_top u_dut (
    .clk, .rst, .start, .busy, .item_key, .item_payload, .last_item,
    .strobe, .out_key, .out_payload, .out_last, .overflowed
  );

  heap_sort_records_checker u_checker (
    .clk, .rst, .start, .busy, .item_key, .item_payload, .last_item,
    .strobe, .out_key, .out_payload, .out_last, .overflowed,
    .fail_count, .pending, .records_sent, .records_sorted
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("heap_sort_records_top_tb: errors");
      $finish;
    end
  end

  task automatic send_record(input hsr_pkg::key_t k, input hsr_pkg::payload_t p,
                             input logic lst);
    while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    item_key <= k;
    item_payload <= p;
    last_item <= lst;
    while (busy) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic send_set(input int n, input int key_span);
    for (int i = 0; i < n; i++) begin
      send_record(hsr_pkg::key_t'($urandom_range(key_span, 0)),
                  hsr_pkg::payload_t'($urandom), i == n - 1);
    end
    set_count++;
  endtask

  initial begin
    int n;
    rst = 1'b1;
    start = 1'b0;
    item_key = '0;
    item_payload = '0;
    last_item = 1'b0;
    idle_pct = 0;
    set_count = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_record(16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    send_record(16'h0000, 32'h0000_0000, 1'b0);
    send_record(16'hFFFF, 32'h1234_5678, 1'b0);
    send_record(16'h0000, 32'hFFFF_FFFF, 1'b0);
    send_record(16'h8000, 32'hA5A5_A5A5, 1'b1);
    send_record(16'h0007, 32'h1, 1'b0);
    send_record(16'h0007, 32'h2, 1'b0);
    send_record(16'h0007, 32'h3, 1'b1);
    set_count += 3;
    send_set(hsr_pkg::MaxRecords, 65535);
    send_set(hsr_pkg::MaxRecords + 3, 65535);
    send_set(hsr_pkg::MaxRecords + 1, 3);

    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = (phase == 1) ? 70 : (phase == 3) ? 15 : 0;
      while (records_sent < 200 + 50 * (phase + 1)) begin
        n = ($urandom_range(9, 0) == 0) ? $urandom_range(hsr_pkg::MaxRecords + 4, 40)
                                        : $urandom_range(12, 1);
        send_set(n, ($urandom_range(1, 0) != 0) ? 65535 : 7);
      end
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("covered %0d record sets, %0d records in, %0d sorted records out",
             set_count, records_sent, records_sorted);
    if (fail_count == 0) begin
      $display("heap_sort_records_top_tb: clean");
    end else begin
      $display("heap_sort_records_top_tb: errors");
    end
    $finish;
  end
endmodule
